// File: hdl/fbt_pkg.sv
package fbt_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_USERS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOG_TERM = 2'd2;

	localparam int LEN_W = 20;
	localparam int USERS_W = 11;
	localparam int LOG_W = 24;
	localparam int USER_IDX_W = 10;

	// result queue
	localparam int QDEPTH = 8;
	localparam int QAW = 3;
	localparam int QCW = 4;
	// room kept free for two pipeline stages and one new item, two results each
	localparam logic [QCW-1:0] QSLACK = 4'(QDEPTH - 6);

	typedef struct packed {
		logic [USER_IDX_W-1:0] user_index;
		logic guilty;
		logic last_verdict;
	} result_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
		logic [USER_IDX_W-1:0] user;
		logic [USER_IDX_W-1:0] last_user;
		logic first_guilty;
		logic last_guilty;
	} blk_ctl_t;

endpackage

// File: hdl/fbt_counter.sv
module fbt_counter #(
	parameter int BLOCK_COUNT_BITS = 20,
	parameter int MAX_USERS = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  logic word_bit,
	input  logic unreadable_bit,
	input  logic [fbt_pkg::LEN_W-1:0] block_length,
	input  logic [fbt_pkg::USERS_W-1:0] num_users,
	output fbt_pkg::blk_ctl_t ctl_s1,
	output logic [BLOCK_COUNT_BITS-1:0] w_ones_s1,
	output logic [BLOCK_COUNT_BITS-1:0] c_ones_s1,
	output logic [BLOCK_COUNT_BITS-1:0] w_marks_s1,
	output logic [BLOCK_COUNT_BITS-1:0] c_marks_s1
);
	import fbt_pkg::*;

	localparam int CB = BLOCK_COUNT_BITS;
	localparam int LW = (CB > LEN_W) ? CB : LEN_W;
	localparam int BNW = (MAX_USERS > 2048) ? USERS_W : $clog2(MAX_USERS);
	localparam logic [16:0] MAXU = 17'(MAX_USERS);

	logic [CB-1:0] bit_q;
	logic [BNW-1:0] blk_q;
	logic [CB-1:0] ones_q;
	logic [CB-1:0] marks_q;
	logic [CB-1:0] ones_prev_q;
	logic [CB-1:0] marks_prev_q;

	logic [LW-1:0] len_x;
	logic [LW-1:0] cap_x;
	logic [CB-1:0] len_eff;
	logic [USERS_W-1:0] n_eff;
	logic [USERS_W-1:0] last_block;
	logic [USERS_W-1:0] blk_x;
	logic [USERS_W-1:0] mid_user;
	logic [USERS_W-1:0] last_user;
	logic [CB-1:0] ones_new;
	logic [CB-1:0] marks_new;
	logic blk_end;
	logic is_last;

	always_comb begin
		len_x = LW'(block_length);
		cap_x = LW'({CB{1'b1}});
		if (len_x == '0) begin
			len_eff = CB'(1);
		end else if (len_x > cap_x) begin
			len_eff = {CB{1'b1}};
		end else begin
			len_eff = len_x[CB-1:0];
		end
		if (num_users < USERS_W'(2)) begin
			n_eff = USERS_W'(2);
		end else if (17'(num_users) > MAXU) begin
			n_eff = MAXU[USERS_W-1:0];
		end else begin
			n_eff = num_users;
		end
		last_block = n_eff - USERS_W'(2);
		last_user = n_eff - USERS_W'(1);
		blk_x = USERS_W'(blk_q);
		mid_user = (blk_x > last_block) ? last_block : blk_x;
		ones_new = ones_q + CB'(word_bit);
		marks_new = marks_q + CB'(unreadable_bit);
		blk_end = ((CB+1)'(bit_q) + (CB+1)'(1)) >= (CB+1)'(len_eff);
		is_last = blk_x >= last_block;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
			blk_q <= '0;
			ones_q <= '0;
			marks_q <= '0;
			ones_prev_q <= '0;
			marks_prev_q <= '0;
		end else if (accept) begin
			if (!blk_end) begin
				bit_q <= bit_q + CB'(1);
				ones_q <= ones_new;
				marks_q <= marks_new;
			end else if (is_last) begin
				bit_q <= '0;
				blk_q <= '0;
				ones_q <= '0;
				marks_q <= '0;
				ones_prev_q <= '0;
				marks_prev_q <= '0;
			end else begin
				bit_q <= '0;
				blk_q <= blk_q + BNW'(1);
				ones_q <= '0;
				marks_q <= '0;
				ones_prev_q <= ones_new;
				marks_prev_q <= marks_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			w_ones_s1 <= '0;
			c_ones_s1 <= '0;
			w_marks_s1 <= '0;
			c_marks_s1 <= '0;
		end else begin
			ctl_s1.valid <= accept && blk_end;
			if (accept && blk_end) begin
				ctl_s1.first <= (blk_q == '0);
				ctl_s1.last <= is_last;
				ctl_s1.user <= (blk_q == '0) ? '0 : mid_user[USER_IDX_W-1:0];
				ctl_s1.last_user <= last_user[USER_IDX_W-1:0];
				ctl_s1.first_guilty <= (ones_new != '0) || (marks_new != '0);
				ctl_s1.last_guilty <= (ones_new < len_eff) || (marks_new != '0);
				w_ones_s1 <= ones_prev_q;
				c_ones_s1 <= ones_new;
				w_marks_s1 <= marks_prev_q;
				c_marks_s1 <= marks_new;
			end
		end
	end

endmodule

// File: hdl/fbt_judge.sv
module fbt_judge #(
	parameter int BLOCK_COUNT_BITS = 20
) (
	input  logic clk,
	input  logic arst_n,
	input  fbt_pkg::blk_ctl_t ctl_s1,
	input  logic [BLOCK_COUNT_BITS-1:0] w_ones_s1,
	input  logic [BLOCK_COUNT_BITS-1:0] c_ones_s1,
	input  logic [BLOCK_COUNT_BITS-1:0] w_marks_s1,
	input  logic [BLOCK_COUNT_BITS-1:0] c_marks_s1,
	input  logic [fbt_pkg::LOG_W-1:0] log_term,
	output logic wr0,
	output logic wr1,
	output fbt_pkg::result_t r0,
	output fbt_pkg::result_t r1
);
	import fbt_pkg::*;

	localparam int CB = BLOCK_COUNT_BITS;
	localparam int DDW = 2 * CB;
	localparam int KLW = CB + 1 + LOG_W;
	localparam int CMPW = (DDW + 16 > KLW + 1) ? DDW + 16 : KLW + 1;

	blk_ctl_t ctl_s2;
	logic pos_ones_s2;
	logic pos_marks_s2;
	logic [DDW-1:0] dd_ones_s2;
	logic [DDW-1:0] dd_marks_s2;
	logic [KLW-1:0] kl_ones_s2;
	logic [KLW-1:0] kl_marks_s2;

	logic [CB-1:0] d_ones;
	logic [CB-1:0] d_marks;
	logic [CB:0] k_ones;
	logic [CB:0] k_marks;
	logic gt_ones;
	logic gt_marks;
	logic mid_guilty;

	always_comb begin
		d_ones = c_ones_s1 - w_ones_s1;
		d_marks = c_marks_s1 - w_marks_s1;
		k_ones = (CB+1)'(c_ones_s1) + (CB+1)'(w_ones_s1);
		k_marks = (CB+1)'(c_marks_s1) + (CB+1)'(w_marks_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			pos_ones_s2 <= 1'b0;
			pos_marks_s2 <= 1'b0;
			dd_ones_s2 <= '0;
			dd_marks_s2 <= '0;
			kl_ones_s2 <= '0;
			kl_marks_s2 <= '0;
		end else begin
			ctl_s2.valid <= ctl_s1.valid;
			if (ctl_s1.valid) begin
				ctl_s2.first <= ctl_s1.first;
				ctl_s2.last <= ctl_s1.last;
				ctl_s2.user <= ctl_s1.user;
				ctl_s2.last_user <= ctl_s1.last_user;
				ctl_s2.first_guilty <= ctl_s1.first_guilty;
				ctl_s2.last_guilty <= ctl_s1.last_guilty;
				pos_ones_s2 <= c_ones_s1 > w_ones_s1;
				pos_marks_s2 <= c_marks_s1 > w_marks_s1;
				dd_ones_s2 <= DDW'(d_ones) * DDW'(d_ones);
				dd_marks_s2 <= DDW'(d_marks) * DDW'(d_marks);
				kl_ones_s2 <= KLW'(k_ones) * KLW'(log_term);
				kl_marks_s2 <= KLW'(k_marks) * KLW'(log_term);
			end
		end
	end

	// (k-2w)^2 * 2^16 > 2*k*L
	always_comb begin
		gt_ones = CMPW'({dd_ones_s2, 16'h0000}) > CMPW'({kl_ones_s2, 1'b0});
		gt_marks = CMPW'({dd_marks_s2, 16'h0000}) > CMPW'({kl_marks_s2, 1'b0});
		mid_guilty = (pos_ones_s2 && gt_ones) || (pos_marks_s2 && gt_marks);
		wr0 = ctl_s2.valid;
		wr1 = ctl_s2.valid && ctl_s2.last;
		r0.user_index = ctl_s2.user;
		r0.guilty = ctl_s2.first ? ctl_s2.first_guilty : mid_guilty;
		r0.last_verdict = 1'b0;
		r1.user_index = ctl_s2.last_user;
		r1.guilty = ctl_s2.last_guilty;
		r1.last_verdict = 1'b1;
	end

endmodule

// File: hdl/fbt_queue.sv
module fbt_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic wr0,
	input  logic wr1,
	input  fbt_pkg::result_t r0,
	input  fbt_pkg::result_t r1,
	input  logic pop,
	output logic not_empty,
	output fbt_pkg::result_t head,
	output logic [fbt_pkg::QCW-1:0] count
);
	import fbt_pkg::*;

	result_t mem_q [QDEPTH];
	logic [QAW-1:0] rd_q;
	logic [QAW-1:0] wr_q;
	logic [QCW-1:0] count_q;
	logic [QAW-1:0] wr_next;
	logic [QCW-1:0] n_wr;

	always_comb begin
		wr_next = wr_q + QAW'(1);
		n_wr = QCW'(wr0) + QCW'(wr1);
		not_empty = count_q != '0;
		head = mem_q[rd_q];
		count = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			wr_q <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				rd_q <= rd_q + QAW'(1);
			end
			wr_q <= wr_q + n_wr[QAW-1:0];
			count_q <= count_q + n_wr - QCW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (wr0) begin
			mem_q[wr_q] <= r0;
		end
		if (wr1) begin
			mem_q[wr_next] <= r1;
		end
	end

endmodule

// File: hdl/fingerprint_block_trace_core.sv
// block tracing core: one suspect word bit and one unreadable mark per input item
// input channel: in_valid / in_stall with word_bit and unreadable_bit; an item is
// taken at a clock edge with in_valid high and in_stall low
// output channel: out_valid / out_stall with user_index, guilty and last_verdict;
// one verdict per user, last_verdict marks the final user of a trace
// a block end gives one verdict, the last block of a trace gives two
// configuration: cfg_we, cfg_index, cfg_data; write only while no item is in flight
// latency: out_valid rises two clock edges after the edge that takes the item that
// ends a block, so its first verdict can leave at the third edge
// throughput: one item per cycle; the output side moves one verdict per cycle,
// so short blocks are limited by the output rate and the eight entry result queue
// the counters update in the accepting cycle, the squared-distance and
// 2*k*L products take one registered multiply stage, the compare feeds the queue
// in_stall rises when the queue cannot take the verdicts of items in flight;
// a stalled output holds its verdict until out_stall falls
// reset clears the counters, the queue and restores block_length 1, num_users 2,
// log_term 1.0; no verdict is lost or repeated under stalls on either side
module fingerprint_block_trace_core #(
	parameter int BLOCK_COUNT_BITS = 20,
	parameter int MAX_USERS = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic word_bit,
	input  logic unreadable_bit,
	output logic out_valid,
	input  logic out_stall,
	output logic [fbt_pkg::USER_IDX_W-1:0] user_index,
	output logic guilty,
	output logic last_verdict,
	input  logic cfg_we,
	input  logic [fbt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fbt_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fbt_pkg::*;

	localparam int CB = BLOCK_COUNT_BITS;

	logic [LEN_W-1:0] block_length_q;
	logic [USERS_W-1:0] num_users_q;
	logic [LOG_W-1:0] log_term_q;

	logic accept;
	logic pop;
	blk_ctl_t ctl_s1;
	logic [CB-1:0] w_ones_s1;
	logic [CB-1:0] c_ones_s1;
	logic [CB-1:0] w_marks_s1;
	logic [CB-1:0] c_marks_s1;
	logic wr0;
	logic wr1;
	result_t r0;
	result_t r1;
	result_t head;
	logic [QCW-1:0] count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_length_q <= LEN_W'(1);
			num_users_q <= USERS_W'(2);
			log_term_q <= LOG_W'(65536);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BLOCK_LENGTH: block_length_q <= cfg_data[LEN_W-1:0];
				REG_NUM_USERS: num_users_q <= cfg_data[USERS_W-1:0];
				REG_LOG_TERM: log_term_q <= cfg_data[LOG_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_stall = count > QSLACK;
	assign accept = in_valid && !in_stall;
	assign pop = out_valid && !out_stall;

	fbt_counter #(
		.BLOCK_COUNT_BITS(BLOCK_COUNT_BITS),
		.MAX_USERS(MAX_USERS)
	) u_counter (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.word_bit(word_bit),
		.unreadable_bit(unreadable_bit),
		.block_length(block_length_q),
		.num_users(num_users_q),
		.ctl_s1(ctl_s1),
		.w_ones_s1(w_ones_s1),
		.c_ones_s1(c_ones_s1),
		.w_marks_s1(w_marks_s1),
		.c_marks_s1(c_marks_s1)
	);

	fbt_judge #(
		.BLOCK_COUNT_BITS(BLOCK_COUNT_BITS)
	) u_judge (
		.clk(clk),
		.arst_n(arst_n),
		.ctl_s1(ctl_s1),
		.w_ones_s1(w_ones_s1),
		.c_ones_s1(c_ones_s1),
		.w_marks_s1(w_marks_s1),
		.c_marks_s1(c_marks_s1),
		.log_term(log_term_q),
		.wr0(wr0),
		.wr1(wr1),
		.r0(r0),
		.r1(r1)
	);

	fbt_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr0(wr0),
		.wr1(wr1),
		.r0(r0),
		.r1(r1),
		.pop(pop),
		.not_empty(out_valid),
		.head(head),
		.count(count)
	);

	assign user_index = head.user_index;
	assign guilty = head.guilty;
	assign last_verdict = head.last_verdict;

endmodule
